// ===== hdl/pdrr_pkg.sv =====
`timescale 1ns / 1ps

package pdrr_pkg;

   // Register file geometry
   localparam int REG_COUNT  = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_WIDTH  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   // Opcodes
   localparam logic [3:0] KIND_STALL    = 4'd0;
   localparam logic [3:0] KIND_LOAD     = 4'd1;
   localparam logic [3:0] KIND_STORE    = 4'd2;
   localparam logic [3:0] KIND_ADD      = 4'd3;
   localparam logic [3:0] KIND_SUB      = 4'd4;
   localparam logic [3:0] KIND_DIV      = 4'd5;
   localparam logic [3:0] KIND_MULT     = 4'd6;
   localparam logic [3:0] KIND_LESS     = 4'd7;
   localparam logic [3:0] KIND_BRANCH   = 4'd8;
   localparam logic [3:0] KIND_NBRANCH  = 4'd9;
   localparam logic [3:0] KIND_LOADSUM  = 4'd10;
   localparam logic [3:0] KIND_STORESUM = 4'd11;

   typedef struct packed {
      logic                  en;
      logic [IDX_WIDTH-1:0]  addr;
      logic [DATA_WIDTH-1:0] data;
   } wr_port_type;

   typedef struct packed {
      logic                 en;        // capture read data this cycle
      logic                 in_range;  // index lies inside the file
      logic [IDX_WIDTH-1:0] addr;
   } rd_port_type;

   // 33-bit signed index inside [0, REG_COUNT)
   function automatic logic idx_in_range(input logic [32:0] idx);
      return !idx[32] && (idx[31:0] < 32'(REG_COUNT));
   endfunction

   // 32-bit write data to a stored entry (low DATA_WIDTH bits, zero fill above 32)
   function automatic logic [DATA_WIDTH-1:0] to_entry(input logic [31:0] d);
      logic [63:0] w;
      w = 64'(d);
      return w[DATA_WIDTH-1:0];
   endfunction

   // Stored entry to the 32-bit operand: sign-extend from DATA_WIDTH, then cut
   function automatic logic [31:0] from_entry(input logic [DATA_WIDTH-1:0] e);
      logic [63:0] w;
      w = 64'($signed(e));
      return w[31:0];
   endfunction

endpackage

// ===== hdl/pdrr_regfile.sv =====
`timescale 1ns / 1ps

module pdrr_regfile
   import pdrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  wr_port_type           wr,
   input  rd_port_type           rd_a,
   input  rd_port_type           rd_b,
   output logic [DATA_WIDTH-1:0] rdata_a,
   output logic                  rok_a,    // 0: entry reads as zero
   output logic [DATA_WIDTH-1:0] rdata_b,
   output logic                  rok_b
);

   logic [DATA_WIDTH-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0]  valid_ff;
   logic [DATA_WIDTH-1:0] rdata_a_ff;
   logic [DATA_WIDTH-1:0] rdata_b_ff;
   logic                  rok_a_ff;
   logic                  rok_b_ff;
   logic                  hit_a;
   logic                  hit_b;

   // write-first: a read of the entry being written takes the new data
   assign hit_a = wr.en && (wr.addr == rd_a.addr);
   assign hit_b = wr.en && (wr.addr == rd_b.addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_a.en) begin
         rdata_a_ff <= hit_a ? wr.data : mem[rd_a.addr];
      end
      if (rd_b.en) begin
         rdata_b_ff <= hit_b ? wr.data : mem[rd_b.addr];
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rok_a_ff <= 1'b0;
         rok_b_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_a.en) begin
            rok_a_ff <= rd_a.in_range && (hit_a || valid_ff[rd_a.addr]);
         end
         if (rd_b.en) begin
            rok_b_ff <= rd_b.in_range && (hit_b || valid_ff[rd_b.addr]);
         end
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
   assign rok_a   = rok_a_ff;
   assign rok_b   = rok_b_ff;

endmodule

// ===== hdl/pipeline_decode_register_read.sv =====
`timescale 1ns / 1ps

// Decode / register-read stage. Each request transfer carries one writeback
// and one instruction; the writeback lands in the register file first, so the
// instruction reads the new value. Results leave in request order, one per
// request. A request passes the register-file read stage, then the output
// register, before its response is valid; throughput is one transfer per
// cycle while the response side is not stalled, limited by the single write
// port and the two read ports of the register file, which are all used in the
// cycle a request is taken. The file clears to zero on reset through
// per-entry valid bits, so no clearing pass is needed. An index outside the
// file reads as zero and raises index_fault.

module pipeline_decode_register_read
   import pdrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] wb_enable, [5:1] wb_index, [37:6] wb_data, [69:38] operand_a,
   // [101:70] operand_b, [133:102] operand_c, [165:134] next_pc, [167:166] zero
   input  logic [167:0] req_tdata,
   // [3:0] kind
   input  logic [3:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] next_pc_out, [63:32] value_a, [95:64] value_b, [127:96] value_c,
   // [128] index_fault, [135:129] zero
   output logic [135:0] rsp_tdata,
   // [3:0] kind_out
   output logic [3:0]   rsp_tuser
);

   // ---------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------
   logic        wb_enable;
   logic [4:0]  wb_index;
   logic [31:0] wb_data;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   logic [31:0] operand_c;
   logic [31:0] next_pc;
   logic [3:0]  kind;

   assign wb_enable = req_tdata[0];
   assign wb_index  = req_tdata[5:1];
   assign wb_data   = req_tdata[37:6];
   assign operand_a = req_tdata[69:38];
   assign operand_b = req_tdata[101:70];
   assign operand_c = req_tdata[133:102];
   assign next_pc   = req_tdata[165:134];
   assign kind      = req_tuser;

   // ---------------------------------------------------------------
   // Flow control: read stage (s1) feeds the output register
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_load;
   logic req_xfer;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_load;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Decode in the request cycle: indices, range checks, file access
   // ---------------------------------------------------------------
   logic [32:0] sum_ab;      // exact sum, used as storesum index
   logic [32:0] idx_a;
   logic [32:0] idx_b;
   logic        uses_a;
   logic        uses_b;
   logic        ok_a;
   logic        ok_b;
   logic        wb_in_range;
   logic        fault_in;

   assign sum_ab = {operand_a[31], operand_a} + {operand_b[31], operand_b};
   assign idx_a  = (kind == KIND_STORESUM) ? sum_ab : {operand_a[31], operand_a};
   assign idx_b  = {operand_b[31], operand_b};
   assign ok_a   = idx_in_range(idx_a);
   assign ok_b   = idx_in_range(idx_b);

   always_comb begin
      case (kind)
         KIND_STORE, KIND_STORESUM: begin
            uses_a = 1'b1;
            uses_b = 1'b0;
         end
         KIND_ADD, KIND_SUB, KIND_DIV, KIND_MULT, KIND_LESS,
         KIND_BRANCH, KIND_NBRANCH: begin
            uses_a = 1'b1;
            uses_b = 1'b1;
         end
         default: begin
            uses_a = 1'b0;
            uses_b = 1'b0;
         end
      endcase
   end

   assign wb_in_range = 32'(wb_index) < 32'(REG_COUNT);
   assign fault_in    = (wb_enable && !wb_in_range)
                      || (uses_a && !ok_a) || (uses_b && !ok_b);

   wr_port_type wr;
   rd_port_type rd_a;
   rd_port_type rd_b;

   assign wr.en         = req_xfer && wb_enable && wb_in_range;
   assign wr.addr       = IDX_WIDTH'(wb_index);
   assign wr.data       = to_entry(wb_data);
   assign rd_a.en       = req_xfer;
   assign rd_a.in_range = ok_a;
   assign rd_a.addr     = idx_a[IDX_WIDTH-1:0];
   assign rd_b.en       = req_xfer;
   assign rd_b.in_range = ok_b;
   assign rd_b.addr     = idx_b[IDX_WIDTH-1:0];

   logic [DATA_WIDTH-1:0] rf_data_a;
   logic [DATA_WIDTH-1:0] rf_data_b;
   logic                  rf_ok_a;
   logic                  rf_ok_b;

   pdrr_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_a    (rd_a),
      .rd_b    (rd_b),
      .rdata_a (rf_data_a),
      .rok_a   (rf_ok_a),
      .rdata_b (rf_data_b),
      .rok_b   (rf_ok_b)
   );

   // ---------------------------------------------------------------
   // Read stage registers (payload, no reset)
   // ---------------------------------------------------------------
   logic [3:0]  s1_kind_ff;
   logic [31:0] s1_pc_ff;
   logic [31:0] s1_a_ff;
   logic [31:0] s1_sum_ff;
   logic [31:0] s1_c_ff;
   logic        s1_fault_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_kind_ff  <= kind;
         s1_pc_ff    <= next_pc;
         s1_a_ff     <= operand_a;
         s1_sum_ff   <= sum_ab[31:0];
         s1_c_ff     <= operand_c;
         s1_fault_ff <= fault_in;
      end
   end

   // ---------------------------------------------------------------
   // Operand select by opcode
   // ---------------------------------------------------------------
   logic [31:0] reg_a;
   logic [31:0] reg_b;
   logic [31:0] value_a_in;
   logic [31:0] value_b_in;
   logic [31:0] value_c_in;

   assign reg_a = rf_ok_a ? from_entry(rf_data_a) : 32'd0;
   assign reg_b = rf_ok_b ? from_entry(rf_data_b) : 32'd0;

   always_comb begin
      value_a_in = 32'd0;
      value_b_in = 32'd0;
      value_c_in = s1_c_ff;
      case (s1_kind_ff)
         KIND_LOAD: begin
            value_a_in = s1_a_ff;
         end
         KIND_LOADSUM: begin
            value_a_in = s1_sum_ff;
         end
         KIND_STORE, KIND_STORESUM: begin
            value_a_in = reg_a;
         end
         KIND_ADD, KIND_SUB, KIND_DIV, KIND_MULT, KIND_LESS,
         KIND_BRANCH, KIND_NBRANCH: begin
            value_a_in = reg_a;
            value_b_in = reg_b;
         end
         default: begin
            value_c_in = 32'd0;   // stall and unknown opcodes
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic [3:0]  kind_out_ff;
   logic [31:0] next_pc_out_ff;
   logic [31:0] value_a_ff;
   logic [31:0] value_b_ff;
   logic [31:0] value_c_ff;
   logic        index_fault_ff;

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         kind_out_ff    <= s1_kind_ff;
         next_pc_out_ff <= s1_pc_ff;
         value_a_ff     <= value_a_in;
         value_b_ff     <= value_b_in;
         value_c_ff     <= value_c_in;
         index_fault_ff <= s1_fault_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_out_ff;
   assign rsp_tdata  = {7'd0, index_fault_ff, value_c_ff, value_b_ff, value_a_ff,
                        next_pc_out_ff};

endmodule

// ===== bench/pipeline_decode_register_read_tb.sv =====
`timescale 1ns / 1ps

module pipeline_decode_register_read_tb;
   import pdrr_pkg::*;

   // One instruction plus its writeback, as carried by a request transfer
   typedef struct packed {
      logic        wb_en;
      logic [4:0]  wb_idx;
      logic [31:0] wb_data;
      logic [3:0]  kind;
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic [31:0] op_c;
      logic [31:0] next_pc;
   } decode_req_type;

   // Decoded operands, as carried by a response transfer
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] next_pc;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [31:0] value_c;
      logic        fault;
   } decode_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [0] wb_enable, [5:1] wb_index, [37:6] wb_data, [69:38] operand_a,
   // [101:70] operand_b, [133:102] operand_c, [165:134] next_pc, [167:166] zero
   logic [167:0] req_tdata = '0;
   // [3:0] kind
   logic [3:0]   req_tuser = '0;

   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [31:0] next_pc_out, [63:32] value_a, [95:64] value_b, [127:96] value_c,
   // [128] index_fault, [135:129] zero
   logic [135:0] rsp_tdata;
   // [3:0] kind_out
   logic [3:0]   rsp_tuser;

   // Shadow register file and the queue of decoded operands still owed
   logic [31:0]    shadow_regs [REG_COUNT];
   decode_rsp_type pending_results [$];
   logic [4:0]     last_wb_idx = '0;

   int unsigned  error_count   = 0;
   int unsigned  items_sent    = 0;
   int unsigned  directed_sent = 0;
   int unsigned  results_seen  = 0;
   int unsigned  faults_seen   = 0;

   // Response-side idling control; the test tasks write the first three with NBAs
   int unsigned  sink_stall_pct = 0;
   int unsigned  hold_len       = 0;
   int unsigned  hold_token     = 0;
   int unsigned  hold_seen      = 0;
   int unsigned  sink_wait      = 0;

   pipeline_decode_register_read u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Hard stop in case a handshake never completes
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Decode model
   // ------------------------------------------------------------------

   // {fault, data}: an index outside the file reads zero and flags a fault
   function automatic logic [32:0] fetch_reg(input longint idx);
      if (idx < 0 || idx >= REG_COUNT)
         return {1'b1, 32'd0};
      return {1'b0, shadow_regs[idx]};
   endfunction

   // Writeback first, then operand selection by opcode
   function automatic decode_rsp_type decode_operands(input decode_req_type instr);
      decode_rsp_type res;
      longint         a;
      longint         b;
      logic [32:0]    rd_a;
      logic [32:0]    rd_b;
      res         = '0;
      a           = longint'($signed(instr.op_a));
      b           = longint'($signed(instr.op_b));
      res.kind    = instr.kind;
      res.next_pc = instr.next_pc;
      if (instr.wb_en) begin
         if (instr.wb_idx < REG_COUNT)
            shadow_regs[instr.wb_idx] = instr.wb_data;
         else
            res.fault = 1'b1;
      end
      case (instr.kind)
         KIND_LOAD: begin
            res.value_a = instr.op_a;
            res.value_c = instr.op_c;
         end
         KIND_STORE: begin
            rd_a        = fetch_reg(a);
            res.value_a = rd_a[31:0];
            res.fault   = res.fault | rd_a[32];
            res.value_c = instr.op_c;
         end
         KIND_ADD, KIND_SUB, KIND_DIV, KIND_MULT, KIND_LESS,
         KIND_BRANCH, KIND_NBRANCH: begin
            rd_a        = fetch_reg(a);
            rd_b        = fetch_reg(b);
            res.value_a = rd_a[31:0];
            res.value_b = rd_b[31:0];
            res.fault   = res.fault | rd_a[32] | rd_b[32];
            res.value_c = instr.op_c;
         end
         KIND_LOADSUM: begin
            res.value_a = instr.op_a + instr.op_b;   // wraps in 32 bits
            res.value_c = instr.op_c;
         end
         KIND_STORESUM: begin
            // exact sum, no wrap: a sum past the 32-bit range is a fault
            rd_a        = fetch_reg(a + b);
            res.value_a = rd_a[31:0];
            res.fault   = res.fault | rd_a[32];
            res.value_c = instr.op_c;
         end
         default: ;   // stall and unknown opcodes: all operands zero
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic decode_req_type make_instr(input logic [3:0] kind,
                                                 input logic [31:0] op_a,
                                                 input logic [31:0] op_b,
                                                 input logic [31:0] op_c,
                                                 input logic wb_en,
                                                 input logic [4:0] wb_idx,
                                                 input logic [31:0] wb_data,
                                                 input logic [31:0] next_pc);
      decode_req_type instr;
      instr.kind    = kind;
      instr.op_a    = op_a;
      instr.op_b    = op_b;
      instr.op_c    = op_c;
      instr.wb_en   = wb_en;
      instr.wb_idx  = wb_idx;
      instr.wb_data = wb_data;
      instr.next_pc = next_pc;
      return instr;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 80)
         return $urandom_range(2);
      if (sel < 95)
         return $urandom_range(8, 3);
      return $urandom_range(40, 20);
   endfunction

   // Register index field: biased toward the last writeback target so reads
   // hit freshly written data, with edges and garbage mixed in
   function automatic logic [31:0] pick_index();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 30)
         return 32'(last_wb_idx);
      if (sel < 75)
         return 32'($urandom_range(REG_COUNT - 1));
      if (sel < 83)
         return 32'($urandom_range(REG_COUNT + 8, REG_COUNT));
      if (sel < 91)
         return 32'd0 - 32'($urandom_range(8, 1));
      return $urandom();
   endfunction

   function automatic decode_req_type random_instr();
      decode_req_type instr;
      int unsigned    sel;
      instr.wb_en   = ($urandom_range(99) < 60);
      instr.wb_idx  = 5'($urandom_range(31));
      instr.wb_data = $urandom();
      if (instr.wb_en)
         last_wb_idx = instr.wb_idx;
      sel = $urandom_range(99);
      if (sel < 8)
         instr.kind = KIND_STALL;
      else if (sel < 16)
         instr.kind = 4'($urandom_range(15, 12));
      else
         instr.kind = 4'($urandom_range(11, 1));
      instr.op_a    = pick_index();
      instr.op_b    = pick_index();
      instr.op_c    = $urandom();
      instr.next_pc = $urandom();
      if (instr.kind == KIND_STORESUM && $urandom_range(3) != 0) begin
         // base plus small signed offset that sums to a picked index
         instr.op_b = 32'($urandom_range(200)) - 32'd100;
         instr.op_a = pick_index() - instr.op_b;
      end
      if (instr.kind == KIND_LOAD || instr.kind == KIND_LOADSUM) begin
         instr.op_a = $urandom();
         instr.op_b = $urandom();
      end
      return instr;
   endfunction

   // Entered at a falling edge; returns at the falling edge after the
   // transfer, with tvalid still high so back-to-back sends never toggle it.
   task automatic send_instr(input decode_req_type instr);
      req_tdata  <= {2'b00, instr.next_pc, instr.op_c, instr.op_b, instr.op_a,
                     instr.wb_data, instr.wb_idx, instr.wb_en};
      req_tuser  <= instr.kind;
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(decode_operands(instr));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Sender stops until every owed response has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic send_directed(input decode_req_type instr);
      send_instr(instr);
      directed_sent++;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned src_pct,
                             input int unsigned sink_pct);
      sink_stall_pct <= sink_pct;
      repeat (count) begin
         send_instr(random_instr());
         if (src_pct != 0 && $urandom_range(99) < src_pct)
            idle_sender(pick_gap());
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         sink_wait  <= hold_len;
         rsp_tready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
         sink_wait  <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 40)
         $display("%0t: %s mismatch, got %h expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      decode_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (want.fault)
               faults_seen++;
            if (rsp_tuser != want.kind)
               report_mismatch("kind_out", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[31:0] != want.next_pc)
               report_mismatch("next_pc_out", rsp_tdata[31:0], want.next_pc);
            if (rsp_tdata[63:32] != want.value_a)
               report_mismatch("value_a", rsp_tdata[63:32], want.value_a);
            if (rsp_tdata[95:64] != want.value_b)
               report_mismatch("value_b", rsp_tdata[95:64], want.value_b);
            if (rsp_tdata[127:96] != want.value_c)
               report_mismatch("value_c", rsp_tdata[127:96], want.value_c);
            if (rsp_tdata[128] != want.fault)
               report_mismatch("index_fault", 32'(rsp_tdata[128]), 32'(want.fault));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // File reads zero after reset, both ends of the index range
   task automatic test_reset_state();
      send_directed(make_instr(KIND_ADD, 32'd0, 32'd31, 32'h1234_5678, 1'b0, 5'd7,
                               32'hFFFF_FFFF, 32'd0));
   endtask

   // Writeback lands before the read of the same transfer; disabled
   // writeback leaves the file alone
   task automatic test_writeback_forwarding();
      send_directed(make_instr(KIND_STORE, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 5'd0,
                               32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_directed(make_instr(KIND_ADD, 32'd31, 32'd0, 32'h8000_0000, 1'b1, 5'd31,
                               32'h8000_0000, 32'h0000_0004));
      send_directed(make_instr(KIND_STORE, 32'd5, 32'd0, 32'd0, 1'b0, 5'd5,
                               32'hDEAD_BEEF, 32'h8000_0000));
   endtask

   // Raw operand passthrough and wrapping sum
   task automatic test_raw_operands();
      send_directed(make_instr(KIND_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                               1'b0, 5'd0, 32'd0, 32'hFFFF_FFFC));
      send_directed(make_instr(KIND_LOADSUM, 32'h7FFF_FFFF, 32'd1, 32'd3, 1'b1, 5'd2,
                               32'h0000_00A5, 32'h0000_0010));
   endtask

   // Out-of-range reads: negative, one past the end, and sums past the top end,
   // one beyond the 32-bit range; then a negative base plus offset in range
   task automatic test_index_faults();
      send_directed(make_instr(KIND_STORE, 32'hFFFF_FFFF, 32'd0, 32'd9, 1'b0, 5'd0,
                               32'd0, 32'd8));
      send_directed(make_instr(KIND_BRANCH, 32'd32, 32'h8000_0000, 32'd1, 1'b1, 5'd1,
                               32'h5555_5555, 32'd12));
      send_directed(make_instr(KIND_STORESUM, 32'd31, 32'd1, 32'd2, 1'b0, 5'd0,
                               32'd0, 32'd16));
      send_directed(make_instr(KIND_STORESUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3,
                               1'b0, 5'd0, 32'd0, 32'd20));
      send_directed(make_instr(KIND_STORESUM, 32'hFFFF_FFFB, 32'd36, 32'd4, 1'b0, 5'd0,
                               32'd0, 32'd24));
   endtask

   // Every opcode once, stall and unknown ones with busy fields
   task automatic test_opcode_sweep();
      for (int k = 0; k < 16; k++)
         send_directed(make_instr(4'(k), 32'($urandom_range(31)), 32'($urandom_range(31)),
                                  $urandom(), 1'b1, 5'($urandom_range(31)), $urandom(),
                                  $urandom()));
   endtask

   // Long response hold-off while the sender keeps offering back-to-back;
   // the stage fills and must stall its request side
   task automatic test_backpressure();
      drain_results();
      hold_len   <= 60;
      hold_token <= hold_token + 1;
      run_random(40, 0, 0);
      drain_results();
   endtask

   // Main sequence
   initial begin
      for (int i = 0; i < REG_COUNT; i++)
         shadow_regs[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sink_stall_pct <= 15;
      test_reset_state();
      test_writeback_forwarding();
      test_raw_operands();
      test_index_faults();
      test_opcode_sweep();
      drain_results();

      run_random(600, 30, 30);        // random idling on both sides
      drain_results();
      run_random(150, 0, 0);          // no idling at all
      test_backpressure();
      run_random(160, 10, 50);        // heavy response stalls

      drain_results();
      repeat (6) @(posedge clock);

      $display("Covered %0d instructions (%0d directed), %0d responses, %0d index faults",
               items_sent, directed_sent, results_seen, faults_seen);
      $display("All 16 opcodes, same-transfer writeback reads, hold-off and drained phases");
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/pdrr_pkg.sv
hdl/pdrr_regfile.sv
hdl/pipeline_decode_register_read.sv
bench/pipeline_decode_register_read_tb.sv
